>>> sv/rc4_pkg.sv
// Shared types and constants for the RC4 keystream generator.
`timescale 1ns / 1ps

package rc4_pkg;

  // Request codes carried in req_type
  localparam logic REQ_KEY = 1'b0;
  localparam logic REQ_GEN = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] key_word;
  } rc4_in_t;

  typedef struct packed {
    logic [7:0] keystream_word;
    logic       not_keyed;
  } rc4_out_t;

  // Source selected when the output register loads
  typedef enum logic [1:0] {
    SRC_KS   = 2'd0,
    SRC_PEND = 2'd1,
    SRC_NK   = 2'd2
  } out_src_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     accept;
    logic     key_swap;
    logic     key_fin;
    logic     gen_swap;
    logic     gen_tread;
    logic     gen_fin;
    logic     out_ld;
    out_src_t out_src;
  } rc4_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic keyed;
  } rc4_stat_t;

endpackage

>>> sv/rc4_dp.sv
// RC4 datapath: permutation RAM, valid bits, indices, key counter and output register.
`timescale 1ns / 1ps

module rc4_dp #(
  parameter int STATE_SIZE = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rc4_pkg::rc4_in_t  in_data,
  input  rc4_pkg::rc4_cmd_t cmd,
  output rc4_pkg::rc4_stat_t stat,
  output rc4_pkg::rc4_out_t out_data
);
  import rc4_pkg::*;

  localparam int IDX_W = (STATE_SIZE > 1) ? $clog2(STATE_SIZE) : 1;
  localparam int SW    = IDX_W + 2;
  localparam logic [SW-1:0]    N_S  = SW'(STATE_SIZE);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(STATE_SIZE - 1);

  // key word reduced modulo the table size, eight conditional subtracts
  function automatic logic [IDX_W-1:0] red_key(input logic [7:0] kw);
    logic [16:0] r;
    r = {9'd0, kw};
    for (int k = 7; k >= 0; k--) begin
      if (r >= (17'(STATE_SIZE) << k)) r = r - (17'(STATE_SIZE) << k);
    end
    return r[IDX_W-1:0];
  endfunction

  // reduce a value below three times the table size
  function automatic logic [IDX_W-1:0] mod_sz(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = s;
    if (r >= N_S) r = r - N_S;
    if (r >= N_S) r = r - N_S;
    return r[IDX_W-1:0];
  endfunction

  logic [IDX_W-1:0] mem [STATE_SIZE];
  logic [STATE_SIZE-1:0] vld_r;

  logic [IDX_W-1:0] rdata_r, raddr_r;
  logic             rvld_r;
  logic [IDX_W-1:0] i_r, j_r, kc_r, kw_r, pos_r, jn_r, a_r, b_r, pend_r;
  logic             keyed_r;
  rc4_out_t         out_r;

  logic [IDX_W-1:0] mem_addr, mem_wdata;
  logic             mem_we;
  logic [IDX_W-1:0] rd_eff, i_inc, jn_c, t_c, ks_eff, addend;
  logic             clr;

  assign rd_eff = rvld_r ? rdata_r : raddr_r;
  assign i_inc  = (i_r == LAST) ? '0 : i_r + 1'b1;
  assign addend = cmd.key_swap ? kw_r : '0;
  assign jn_c   = mod_sz(SW'(j_r) + SW'(rd_eff) + SW'(addend));
  assign t_c    = mod_sz(SW'(a_r) + SW'(rd_eff));
  // S[i] is written last, so a lookup that lands on it takes the swapped value
  assign ks_eff = (raddr_r == pos_r) ? b_r : rd_eff;
  assign clr    = cmd.accept && (in_data.req_type == REQ_KEY) && (kc_r == '0);

  always_comb begin
    mem_addr  = (in_data.req_type == REQ_GEN) ? i_inc : kc_r;
    mem_we    = 1'b0;
    mem_wdata = rd_eff;
    if (cmd.key_swap || cmd.gen_swap) begin
      mem_addr = jn_c;
      mem_we   = 1'b1;
    end else if (cmd.gen_tread) begin
      mem_addr = t_c;
    end else if (cmd.key_fin) begin
      mem_addr = pos_r;
      mem_we   = 1'b1;
    end else if (cmd.gen_fin) begin
      mem_addr  = pos_r;
      mem_we    = 1'b1;
      mem_wdata = b_r;
    end
  end

  // single-port table, read-first
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_r <= mem[mem_addr];
    raddr_r <= mem_addr;
    rvld_r  <= vld_r[mem_addr] & ~clr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
      kc_r    <= '0;
      keyed_r <= 1'b0;
    end else begin
      if (clr) begin
        vld_r   <= '0;
        keyed_r <= 1'b0;
        i_r     <= '0;
        j_r     <= '0;
      end else if (mem_we) begin
        vld_r[mem_addr] <= 1'b1;
      end
      if (cmd.key_fin) begin
        if (kc_r == LAST) begin
          kc_r    <= '0;
          keyed_r <= 1'b1;
          i_r     <= '0;
          j_r     <= '0;
        end else begin
          kc_r <= kc_r + 1'b1;
          j_r  <= jn_r;
        end
      end
      if (cmd.gen_fin) begin
        i_r <= pos_r;
        j_r <= jn_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kw_r  <= red_key(in_data.key_word);
      pos_r <= (in_data.req_type == REQ_GEN) ? i_inc : kc_r;
    end
    if (cmd.key_swap || cmd.gen_swap) begin
      a_r  <= rd_eff;
      jn_r <= jn_c;
    end
    if (cmd.gen_tread) b_r <= rd_eff;
    if (cmd.gen_fin) pend_r <= ks_eff;
    if (cmd.out_ld) begin
      case (cmd.out_src)
        SRC_KS:   out_r <= '{keystream_word: 8'(ks_eff), not_keyed: 1'b0};
        SRC_PEND: out_r <= '{keystream_word: 8'(pend_r), not_keyed: 1'b0};
        default:  out_r <= '{keystream_word: 8'd0, not_keyed: 1'b1};
      endcase
    end
  end

  assign stat.keyed = keyed_r;
  assign out_data   = out_r;

endmodule

>>> sv/rc4_ctrl.sv
// RC4 controller: sequences key steps, generation steps and output handoff.
`timescale 1ns / 1ps

module rc4_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               req_type,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  rc4_pkg::rc4_stat_t stat,
  output rc4_pkg::rc4_cmd_t  cmd
);
  import rc4_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_KSWP, ST_KFIN, ST_GSWP, ST_GRD, ST_GFIN, ST_OUTW, ST_NKW
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free, acc;

  assign out_free = !out_valid_r || !out_stall;
  assign acc      = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.out_src = SRC_KS;
    cmd.accept  = acc;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (req_type == REQ_KEY) begin
            state_nxt = ST_KSWP;
          end else if (!stat.keyed) begin
            if (out_free) begin
              cmd.out_ld  = 1'b1;
              cmd.out_src = SRC_NK;
            end else begin
              state_nxt = ST_NKW;
            end
          end else begin
            state_nxt = ST_GSWP;
          end
        end
      end
      ST_KSWP: begin
        cmd.key_swap = 1'b1;
        state_nxt    = ST_KFIN;
      end
      ST_KFIN: begin
        cmd.key_fin = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_GSWP: begin
        cmd.gen_swap = 1'b1;
        state_nxt    = ST_GRD;
      end
      ST_GRD: begin
        cmd.gen_tread = 1'b1;
        state_nxt     = ST_GFIN;
      end
      ST_GFIN: begin
        cmd.gen_fin = 1'b1;
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_OUTW;
        end
      end
      ST_OUTW: begin
        if (out_free) begin
          cmd.out_ld  = 1'b1;
          cmd.out_src = SRC_PEND;
          state_nxt   = ST_IDLE;
        end
      end
      ST_NKW: begin
        if (out_free) begin
          cmd.out_ld  = 1'b1;
          cmd.out_src = SRC_NK;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cmd.out_ld) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> sv/rc4_keystream_generator_top.sv
// Top level of the RC4 keystream generator: controller plus datapath.
`timescale 1ns / 1ps

// RC4 keystream generator. Input transactions carry either a key word
// (req_type 0) or a keystream request (req_type 1). The first key word of a
// session restores the permutation to identity; STATE_SIZE key words complete
// the key schedule and clear both indices. Each keystream request yields one
// output transaction holding the next keystream word; a request made before
// keying finishes yields zero with not_keyed set and leaves the state alone.
// Key words yield no output. The input stalls while a transaction is worked on;
// the single read-first port of the permutation RAM orders its steps (read
// S[i], read and write S[j], then lookup and write S[i]). One finished
// result may wait in the output register while the next transaction is taken.
// Reset and each new session restore identity at once through per-entry valid
// bits, so there is no clearing pass.

module rc4_keystream_generator_top #(
  parameter int STATE_SIZE = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rc4_pkg::rc4_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rc4_pkg::rc4_out_t out_data
);
  import rc4_pkg::*;

  rc4_cmd_t  cmd;
  rc4_stat_t stat;

  // Sequencer: one transaction in flight, stalls the input while busy
  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .req_type  (in_data.req_type),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Permutation RAM, indices and output payload register
  rc4_dp #(
    .STATE_SIZE (STATE_SIZE)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

>>> sim/rc4_keystream_generator_top_tb.sv
// Self-checking testbench for the RC4 keystream generator top level.
`timescale 1ns / 1ps

module rc4_keystream_generator_top_tb;
  import rc4_pkg::*;

  localparam int STATE_SIZE  = 256;
  localparam int HOLD_CYCLES = 300;     // long receiver hold-off, fills the block
  localparam int DRAIN_WAIT  = 40;      // wait after the final drain, plenty of margin
  localparam int CYCLE_LIMIT = 500000;  // watchdog

  // Scoreboard: keeps its own copy of the permutation and indices, turns
  // every accepted input transaction into the expected output (if any) and
  // compares returned transactions in order.
  class rc4_scoreboard;
    logic [7:0]  perm [256];
    logic [7:0]  idx_i;
    logic [7:0]  idx_j;
    int unsigned keys_taken;  // key words taken in the current session
    bit          keyed;
    rc4_out_t    expq [$];
    int          fails;
    int          n_results;

    function new();
      restore_identity();
      idx_i      = '0;
      idx_j      = '0;
      keys_taken = 0;
      keyed      = 1'b0;
      fails      = 0;
      n_results  = 0;
    endfunction

    function void restore_identity();
      for (int k = 0; k < 256; k++) perm[k] = k[7:0];
    endfunction

    function void swap_entries(logic [7:0] a, logic [7:0] b);
      logic [7:0] t;
      t       = perm[a];
      perm[a] = perm[b];
      perm[b] = t;
    endfunction

    function int pending();
      return expq.size();
    endfunction

    // One key-scheduling step; first word of a session restarts from identity.
    function void schedule_key(logic [7:0] kw);
      logic [7:0] pos;
      if (keys_taken == 0) begin
        restore_identity();
        keyed = 1'b0;
        idx_i = '0;
        idx_j = '0;
      end
      pos   = keys_taken[7:0];
      idx_j = 8'((int'(idx_j) + int'(perm[pos]) + int'(kw)) % STATE_SIZE);
      swap_entries(pos, idx_j);
      keys_taken++;
      if (keys_taken >= STATE_SIZE) begin
        keys_taken = 0;
        keyed      = 1'b1;
        idx_i      = '0;
        idx_j      = '0;
      end
    endfunction

    // One PRGA step; an unkeyed request leaves the state alone.
    function void generate_word();
      rc4_out_t   r;
      logic [7:0] t;
      if (!keyed) begin
        r.keystream_word = '0;
        r.not_keyed      = 1'b1;
      end else begin
        idx_i = 8'((int'(idx_i) + 1) % STATE_SIZE);
        idx_j = 8'((int'(idx_j) + int'(perm[idx_i])) % STATE_SIZE);
        swap_entries(idx_i, idx_j);
        t = 8'((int'(perm[idx_i]) + int'(perm[idx_j])) % STATE_SIZE);
        r.keystream_word = perm[t];
        r.not_keyed      = 1'b0;
      end
      expq = {expq, r};
    endfunction

    function void note_input(rc4_in_t item);
      if (item.req_type == REQ_KEY) schedule_key(item.key_word);
      else generate_word();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      fails++;
    endtask

    task check_result(rc4_out_t got);
      rc4_out_t want;
      n_results++;
      if (expq.size() == 0) begin
        report($sformatf("result %0d unexpected: ks=%02h nk=%0b",
                         n_results, got.keystream_word, got.not_keyed));
        return;
      end
      want = expq.pop_front();
      if (got.keystream_word !== want.keystream_word)
        report($sformatf("result %0d keystream_word %02h, want %02h",
                         n_results, got.keystream_word, want.keystream_word));
      if (got.not_keyed !== want.not_keyed)
        report($sformatf("result %0d not_keyed %0b, want %0b",
                         n_results, got.not_keyed, want.not_keyed));
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  rc4_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rc4_out_t out_data;

  rc4_scoreboard sb;

  bit tx_eager = 1'b0;   // sender offers back to back, no gaps
  bit hold_req = 1'b0;   // asks the receiver for one long hold-off
  int cycle_count = 0;

  always #1 clk = ~clk;

  rc4_keystream_generator_top #(
    .STATE_SIZE(STATE_SIZE)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Watchdog: ends the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[rc4_keystream_generator_top] ERROR");
      $finish;
    end
  end

  // Output side: every transaction taken at a rising edge is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver stall pattern, driven at the falling edge. Runs of free cycles
  // (some long) alternate with stalls; on request one long hold-off is
  // counted here while the sender keeps going.
  initial begin : rx_stall_gen
    int run;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= 1'b0;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
      repeat (run) @(negedge clk);
      run = idle_len();
      if (run > 0) begin
        out_stall <= 1'b1;
        repeat (run) @(negedge clk);
      end
    end
  end

  // Offer one transaction. Called at a falling edge right after the previous
  // acceptance (or after a pause), so valid is touched once per time step.
  task automatic send(rc4_in_t item);
    int gap;
    gap = tx_eager ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_data  <= rc4_in_t'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_input(item);
    @(negedge clk);
  endtask

  task automatic send_key(logic [7:0] kw);
    rc4_in_t t;
    t.req_type = REQ_KEY;
    t.key_word = kw;
    send(t);
  endtask

  task automatic send_gen(logic [7:0] junk);
    rc4_in_t t;
    t.req_type = REQ_GEN;
    t.key_word = junk;
    send(t);
  endtask

  // Key words with random content; extremes show up now and then.
  // gen_pct mixes in keystream requests, which stay unkeyed mid-session.
  task automatic key_words(int count, int gen_pct);
    int         k;
    logic [7:0] kw;
    k = 0;
    while (k < count) begin
      if ($urandom_range(0, 99) < gen_pct) begin
        send_gen(8'($urandom));
      end else begin
        case ($urandom_range(0, 19))
          0:       kw = 8'h00;
          1:       kw = 8'hFF;
          default: kw = 8'($urandom);
        endcase
        send_key(kw);
        k++;
      end
    end
  endtask

  task automatic gen_words(int count);
    repeat (count) send_gen(8'($urandom));
  endtask

  // Sender pause: drop valid and wait out every outstanding result.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  initial begin : main_seq
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: requests before any key, a partial key with extreme words,
    // a request mid-session (key_word must be ignored).
    send_gen(8'h00);
    send_gen(8'hFF);
    send_key(8'h00);
    send_key(8'hFF);
    send_key(8'h55);
    send_key(8'hAA);
    send_key(8'h01);
    send_key(8'h80);
    send_gen(8'h5A);
    drain();

    // Complete the first session, then the first keyed words.
    key_words(STATE_SIZE - 6, 0);
    gen_words(20);

    // Long receiver hold-off while requests keep coming back to back:
    // output register and pending result fill, in_stall must rise. The sender
    // waits for the hold-off to begin so the two overlap.
    drain();
    hold_req = 1'b1;
    wait (!hold_req);
    @(negedge clk);
    tx_eager = 1'b1;
    gen_words(25);
    tx_eager = 1'b0;
    gen_words(15);
    drain();

    // Key word after keying starts a new session; requests mixed in
    // during scheduling must come back unkeyed.
    key_words(STATE_SIZE, 8);
    tx_eager = 1'b1;
    gen_words(15);
    tx_eager = 1'b0;
    gen_words(30);
    drain();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));

    if (sb.fails == 0) begin
      $display("[rc4_keystream_generator_top] OK");
    end else begin
      $display("[rc4_keystream_generator_top] ERROR");
    end
    $finish;
  end

endmodule
